// File: rtl/clt_pkg.sv
// ----------------------------------------------------------------------------
// clt_pkg
// shared constants and types for the command line tokenizer
// ----------------------------------------------------------------------------
package clt_pkg;

  // result field widths
  localparam int IDX_W  = 2;
  localparam int TEXT_W = 64;
  localparam int LENF_W = 4;
  localparam int VAL_W  = 10;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  // decimal weights
  localparam logic [VAL_W-1:0] DEC_TEN     = 10'd10;
  localparam logic [VAL_W-1:0] DEC_HUNDRED = 10'd100;

  // handover from line assembler to result emitter
  typedef struct packed {
    logic take;  // line end item accepted, snapshot the line
    logic ovf;   // line overran
  } line_ctl_t;

endpackage

// File: rtl/clt_line.sv
// ----------------------------------------------------------------------------
// clt_line
// line assembler: collects token characters, counts tokens, flags overrun
// ----------------------------------------------------------------------------
module clt_line #(
  parameter int MAX_TOKENS  = 3,
  parameter int TOKEN_CHARS = 8,
  parameter int TW          = 8 * TOKEN_CHARS,
  parameter int LEN_W       = $clog2(TOKEN_CHARS + 1),
  parameter int CNT_W       = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                acc,
  input  logic [7:0]                          rx_byte,
  output logic [MAX_TOKENS-1:0][TW-1:0]       store,
  output logic [MAX_TOKENS-1:0][LEN_W-1:0]    lens,
  output logic [CNT_W-1:0]                    count,
  output clt_pkg::line_ctl_t                  ctl
);
  import clt_pkg::*;

  logic [MAX_TOKENS-1:0][TW-1:0]    store_r, store_nxt;
  logic [MAX_TOKENS-1:0][LEN_W-1:0] lens_r, lens_nxt;
  logic [CNT_W-1:0]                 count_r, count_nxt;
  logic                             ovf_r, ovf_nxt;
  logic                             early_r, early_nxt;
  logic [LEN_W-1:0]                 cur_len;

  assign cur_len = lens_r[count_r];

  always_comb begin
    store_nxt = store_r;
    lens_nxt  = lens_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    early_nxt = early_r;
    if (acc) begin
      if (rx_byte == CH_CR) begin
        store_nxt = '0;
        lens_nxt  = '0;
        count_nxt = '0;
        ovf_nxt   = 1'b0;
        early_nxt = 1'b0;
      end else if (!ovf_r && !early_r) begin
        if (rx_byte == CH_NUL) begin
          early_nxt = 1'b1;
        end else if (rx_byte == CH_SPACE) begin
          if (int'(count_r) + 1 >= MAX_TOKENS) begin
            ovf_nxt = 1'b1;
          end else begin
            count_nxt = count_r + 1'b1;
          end
        end else if (cur_len >= LEN_W'(TOKEN_CHARS)) begin
          ovf_nxt = 1'b1;
        end else begin
          for (int k = 0; k < TOKEN_CHARS; k++) begin
            if (cur_len == LEN_W'(k)) begin
              store_nxt[count_r][8*k +: 8] = rx_byte;
            end
          end
          lens_nxt[count_r] = cur_len + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r <= '0;
      lens_r  <= '0;
      count_r <= '0;
      ovf_r   <= 1'b0;
      early_r <= 1'b0;
    end else begin
      store_r <= store_nxt;
      lens_r  <= lens_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      early_r <= early_nxt;
    end
  end

  assign store    = store_r;
  assign lens     = lens_r;
  assign count    = count_r;
  assign ctl.take = acc && (rx_byte == CH_CR);
  assign ctl.ovf  = ovf_r;

endmodule

// File: rtl/clt_emit.sv
// ----------------------------------------------------------------------------
// clt_emit
// result emitter: holds a snapshot of the finished line and sends one result
// per token (one error result on overrun) through a registered output stage
// ----------------------------------------------------------------------------
module clt_emit #(
  parameter int MAX_TOKENS  = 3,
  parameter int TOKEN_CHARS = 8,
  parameter int TW          = 8 * TOKEN_CHARS,
  parameter int LEN_W       = $clog2(TOKEN_CHARS + 1),
  parameter int CNT_W       = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  clt_pkg::line_ctl_t                 ctl,
  input  logic [MAX_TOKENS-1:0][TW-1:0]      store,
  input  logic [MAX_TOKENS-1:0][LEN_W-1:0]   lens,
  input  logic [CNT_W-1:0]                   count,
  input  logic                               out_stall,
  output logic                               busy,
  output logic                               out_valid,
  output logic [clt_pkg::IDX_W-1:0]          out_token_index,
  output logic [clt_pkg::TEXT_W-1:0]         out_token_text,
  output logic [clt_pkg::LENF_W-1:0]         out_token_length,
  output logic [clt_pkg::VAL_W-1:0]          out_number_value,
  output logic                               out_number_valid,
  output logic                               out_line_error,
  output logic                               out_last
);
  import clt_pkg::*;

  logic [MAX_TOKENS-1:0][TW-1:0]    snap_store_r;
  logic [MAX_TOKENS-1:0][LEN_W-1:0] snap_lens_r;
  logic [CNT_W-1:0]                 snap_cnt_r;
  logic                             snap_ovf_r;
  logic                             busy_r, busy_nxt;
  logic [CNT_W-1:0]                 idx_r, idx_nxt;
  logic                             valid_r, valid_nxt;
  logic                             adv;

  logic [IDX_W-1:0]  index_r, index_nxt;
  logic [TEXT_W-1:0] text_r, text_nxt;
  logic [LENF_W-1:0] len_r, len_nxt;
  logic [VAL_W-1:0]  value_r, value_nxt;
  logic              nvalid_r, nvalid_nxt;
  logic              err_r, err_nxt;
  logic              last_r, last_nxt;

  // decode of the token under the emit index
  logic [TW-1:0]    cur_text;
  logic [LENF_W-1:0] cur_len;
  logic [7:0]       b0, b1, b2;
  logic             dig0, dig1, dig2;
  logic [VAL_W-1:0] d0, d1, d2;
  logic             num_ok;
  logic [VAL_W-1:0] num_val;
  logic             is_last;

  assign cur_text = snap_store_r[idx_r];
  assign cur_len  = LENF_W'(snap_lens_r[idx_r]);
  assign b0 = cur_text[7:0];
  assign b1 = cur_text[15:8];
  assign b2 = cur_text[23:16];
  assign dig0 = (b0 >= CH_ZERO) && (b0 <= CH_NINE);
  assign dig1 = (b1 >= CH_ZERO) && (b1 <= CH_NINE);
  assign dig2 = (b2 >= CH_ZERO) && (b2 <= CH_NINE);
  assign d0 = VAL_W'(b0 - CH_ZERO);
  assign d1 = VAL_W'(b1 - CH_ZERO);
  assign d2 = VAL_W'(b2 - CH_ZERO);

  always_comb begin
    num_ok = (cur_len >= 4'd1) && (cur_len <= 4'd3) && dig0
             && ((cur_len < 4'd2) || dig1) && ((cur_len < 4'd3) || dig2);
    if (cur_len == 4'd1) begin
      num_val = d0;
    end else if (cur_len == 4'd2) begin
      num_val = d0 * DEC_TEN + d1;
    end else begin
      num_val = d0 * DEC_HUNDRED + d1 * DEC_TEN + d2;
    end
    if (!num_ok) begin
      num_val = '0;
    end
  end

  assign is_last = (idx_r == snap_cnt_r);
  assign adv     = busy_r && (!valid_r || !out_stall);

  always_comb begin
    busy_nxt   = busy_r;
    idx_nxt    = idx_r;
    valid_nxt  = valid_r;
    index_nxt  = index_r;
    text_nxt   = text_r;
    len_nxt    = len_r;
    value_nxt  = value_r;
    nvalid_nxt = nvalid_r;
    err_nxt    = err_r;
    last_nxt   = last_r;
    if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
    if (adv) begin
      valid_nxt = 1'b1;
      if (snap_ovf_r) begin
        index_nxt  = '0;
        text_nxt   = '0;
        len_nxt    = '0;
        value_nxt  = '0;
        nvalid_nxt = 1'b0;
        err_nxt    = 1'b1;
        last_nxt   = 1'b1;
        busy_nxt   = 1'b0;
      end else begin
        index_nxt  = IDX_W'(idx_r);
        text_nxt   = TEXT_W'(cur_text);
        len_nxt    = cur_len;
        value_nxt  = num_val;
        nvalid_nxt = num_ok;
        err_nxt    = 1'b0;
        last_nxt   = is_last;
        if (is_last) begin
          busy_nxt = 1'b0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
    end
    if (ctl.take) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    index_r  <= index_nxt;
    text_r   <= text_nxt;
    len_r    <= len_nxt;
    value_r  <= value_nxt;
    nvalid_r <= nvalid_nxt;
    err_r    <= err_nxt;
    last_r   <= last_nxt;
    if (ctl.take) begin
      snap_store_r <= store;
      snap_lens_r  <= lens;
      snap_cnt_r   <= count;
      snap_ovf_r   <= ctl.ovf;
    end
  end

  assign busy             = busy_r;
  assign out_valid        = valid_r;
  assign out_token_index  = index_r;
  assign out_token_text   = text_r;
  assign out_token_length = len_r;
  assign out_number_value = value_r;
  assign out_number_valid = nvalid_r;
  assign out_line_error   = err_r;
  assign out_last         = last_r;

endmodule

// File: rtl/command_line_tokenizer.sv
// ----------------------------------------------------------------------------
// command_line_tokenizer
// splits a carriage-return terminated line into space separated tokens and
// reports each token's text, length and small decimal value
// ----------------------------------------------------------------------------
// throughput: one received byte per cycle; a line end byte is held off only
//   while the previous line's results are still being sent
// results: the line is snapshotted first, then its first result registered;
//   one result per cycle unless out_stall holds (token count, or one on overrun)
// reset: rst_n synchronous active low, clears the line, emitter state and out_valid
module command_line_tokenizer #(
  parameter int MAX_TOKENS  = 3,
  parameter int TOKEN_CHARS = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // received byte channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   in_rx_byte,
  // token result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [clt_pkg::IDX_W-1:0]    out_token_index,
  output logic [clt_pkg::TEXT_W-1:0]   out_token_text,
  output logic [clt_pkg::LENF_W-1:0]   out_token_length,
  output logic [clt_pkg::VAL_W-1:0]    out_number_value,
  output logic                         out_number_valid,
  output logic                         out_line_error,
  output logic                         out_last
);
  import clt_pkg::*;

  localparam int TW    = 8 * TOKEN_CHARS;
  localparam int LEN_W = $clog2(TOKEN_CHARS + 1);
  localparam int CNT_W = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;

  logic                             in_acc;
  logic                             emit_busy;
  line_ctl_t                        line_ctl;
  logic [MAX_TOKENS-1:0][TW-1:0]    line_store;
  logic [MAX_TOKENS-1:0][LEN_W-1:0] line_lens;
  logic [CNT_W-1:0]                 line_count;

  // the emitter keeps its own copy of a finished line, so the next line's
  // bytes keep flowing in; only a further line end has to wait for it
  assign in_stall = emit_busy && (in_rx_byte == CH_CR);
  assign in_acc   = in_valid && !in_stall;

  // per byte update of the line being assembled
  clt_line #(
    .MAX_TOKENS  (MAX_TOKENS),
    .TOKEN_CHARS (TOKEN_CHARS)
  ) u_line (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (in_acc),
    .rx_byte (in_rx_byte),
    .store   (line_store),
    .lens    (line_lens),
    .count   (line_count),
    .ctl     (line_ctl)
  );

  // snapshot of the line, number decode and registered result stage
  clt_emit #(
    .MAX_TOKENS  (MAX_TOKENS),
    .TOKEN_CHARS (TOKEN_CHARS)
  ) u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (line_ctl),
    .store            (line_store),
    .lens             (line_lens),
    .count            (line_count),
    .out_stall        (out_stall),
    .busy             (emit_busy),
    .out_valid        (out_valid),
    .out_token_index  (out_token_index),
    .out_token_text   (out_token_text),
    .out_token_length (out_token_length),
    .out_number_value (out_number_value),
    .out_number_valid (out_number_valid),
    .out_line_error   (out_line_error),
    .out_last         (out_last)
  );

`ifndef SYNTHESIS
  // an overrun line gives a single result, so its error result ends the line
  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_line_error |-> out_last)
    else $error("error result without last");

  // a valid number always comes from a one to three character token
  a_num_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_number_valid |->
      (out_token_length == 4'd1) || (out_token_length == 4'd2) ||
      (out_token_length == 4'd3))
    else $error("number valid on bad token length");

  // an accepted line end always starts the emitter
  a_cr_starts_emit: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_rx_byte == CH_CR) |=> emit_busy)
    else $error("line end did not start result emission");
`endif

endmodule
